// ===== rtl/core/smbw_pkg.sv =====
package smbw_pkg;

	localparam logic [7:0] END_MARKER_TYPE = 8'd127;
	localparam logic [7:0] MIN_HEADER_LEN  = 8'd4;
	localparam logic [7:0] LAST_HDR_POS    = 8'd3;
	localparam logic [7:0] COUNT_MAX       = 8'hFF;
	localparam logic [15:0] ORDINAL_MAX    = 16'hFFFF;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_END     = 3'd1;
	localparam logic [2:0] ST_BADHDR  = 3'd2;
	localparam logic [2:0] ST_UNTERM  = 3'd3;
	localparam logic [2:0] ST_DATAEND = 3'd4;

	typedef enum logic [3:0] {
		PH_HEADER    = 4'b0001,
		PH_STR_FIRST = 4'b0010,
		PH_STR       = 4'b0100,
		PH_DRAIN     = 4'b1000
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [7:0]  byte_position;
		logic [7:0]  held_type;
		logic [7:0]  held_length;
		logic        prev_zero;
		logic [7:0]  strings_seen;
		logic [15:0] structures_accepted;
	} walk_state_t;

	typedef struct packed {
		logic [7:0]  struct_type;
		logic [7:0]  formatted_length;
		logic [7:0]  string_count;
		logic [15:0] struct_ordinal;
		logic [2:0]  status;
		logic        table_done;
	} walk_result_t;

	function automatic walk_state_t walk_reset_state();
		walk_state_t s;
		s.phase               = PH_HEADER;
		s.byte_position       = '0;
		s.held_type           = '0;
		s.held_length         = '0;
		s.prev_zero           = 1'b0;
		s.strings_seen        = '0;
		s.structures_accepted = '0;
		return s;
	endfunction

endpackage

// ===== rtl/core/smbw_step.sv =====
module smbw_step
	import smbw_pkg::*;
(
	input  walk_state_t  state_cur,
	input  logic [7:0]   data_byte,
	input  logic         last_byte,
	output walk_state_t  state_nxt,
	output logic         emit,
	output walk_result_t result
);

	walk_state_t s;
	logic        emit_c;
	logic [2:0]  status_c;
	logic        done_c;
	logic [8:0]  pos_inc;
	logic        hdr_full;
	logic        new_string;

	assign pos_inc = {1'b0, state_cur.byte_position} + 9'd1;

	always_comb begin
		s          = state_cur;
		emit_c     = 1'b0;
		status_c   = ST_OK;
		done_c     = 1'b1;
		hdr_full   = state_cur.byte_position >= LAST_HDR_POS;
		new_string = 1'b0;
		result     = '0;

		case (state_cur.phase)
			PH_HEADER: begin
				if (state_cur.byte_position == 8'd0) begin
					s.held_type = data_byte;
				end else if (state_cur.byte_position == 8'd1) begin
					s.held_length = data_byte;
				end
				if (hdr_full && s.held_length < MIN_HEADER_LEN) begin
					emit_c   = 1'b1;
					status_c = ST_BADHDR;
					s.phase  = PH_DRAIN;
				end else if (hdr_full && pos_inc == {1'b0, s.held_length}) begin
					if (s.held_type == END_MARKER_TYPE) begin
						emit_c   = 1'b1;
						status_c = ST_END;
						s.phase  = PH_DRAIN;
					end else if (last_byte) begin
						emit_c   = 1'b1;
						status_c = ST_UNTERM;
					end else begin
						s.phase     = PH_STR_FIRST;
						s.prev_zero = 1'b0;
					end
				end else if (last_byte) begin
					emit_c   = 1'b1;
					status_c = hdr_full ? ST_BADHDR : ST_DATAEND;
				end else begin
					s.byte_position = pos_inc[7:0];
				end
			end
			PH_STR_FIRST, PH_STR: begin
				if (state_cur.phase == PH_STR && data_byte == 8'd0 && state_cur.prev_zero) begin
					emit_c   = 1'b1;
					status_c = ST_OK;
					done_c   = last_byte;
				end else begin
					// A string starts on a nonzero byte at the area start or after a zero.
					new_string = (data_byte != 8'd0)
						&& (state_cur.phase == PH_STR_FIRST || state_cur.prev_zero);
					if (new_string && state_cur.strings_seen != COUNT_MAX) begin
						s.strings_seen = state_cur.strings_seen + 8'd1;
					end
					s.prev_zero = (data_byte == 8'd0);
					s.phase     = PH_STR;
					if (last_byte) begin
						emit_c   = 1'b1;
						status_c = ST_UNTERM;
					end
				end
			end
			default: begin
			end
		endcase

		result.struct_type      = s.held_type;
		result.formatted_length = s.held_length;
		result.string_count     = s.strings_seen;
		result.struct_ordinal   = state_cur.structures_accepted;
		result.status           = status_c;
		result.table_done       = done_c;

		state_nxt = s;
		if (emit_c && status_c == ST_OK && (state_cur.phase == PH_STR)) begin
			state_nxt = walk_reset_state();
			state_nxt.structures_accepted = (state_cur.structures_accepted != ORDINAL_MAX)
				? state_cur.structures_accepted + 16'd1 : state_cur.structures_accepted;
		end
		// The final byte of the buffer always leaves the walker ready for a new table.
		if (last_byte) begin
			state_nxt = walk_reset_state();
		end
	end

	assign emit = emit_c;

endmodule

// ===== rtl/core/smbios_structure_walker.sv =====
// SMBIOS structure table walker.
// The input channel (in_valid, in_stall, data_byte, last_byte) takes the table one
// byte per transfer; last_byte marks the final byte of the buffer. The output channel
// (out_valid, out_stall and the result fields) carries one result per completed
// structure or per stop of the walk, with status and table_done.
// A byte is first held in an input register; when it leaves that register the walk state is
// updated and any result is written to the output register, from which it is offered.
// One byte per cycle is sustained while out_stall does not hold back a result.
// While a result waits in the output register under out_stall, bytes that produce no
// result keep flowing; a byte that would produce one waits in the input register and
// in_stall rises until the output register is free.
// After a stop, bytes are ignored until last_byte; the byte with last_byte always
// returns the walker to the start of a new table.
// Reset clears the walk state, the structure counter and both valid flags.
module smbios_structure_walker
	import smbw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  struct_type,
	output logic [7:0]  formatted_length,
	output logic [7:0]  string_count,
	output logic [15:0] struct_ordinal,
	output logic [2:0]  status,
	output logic        table_done
);

	logic         valid_s1;
	logic [7:0]   data_s1;
	logic         last_s1;
	walk_state_t  state_q;
	walk_state_t  state_nxt;
	logic         emit;
	walk_result_t result;
	logic         out_valid_q;
	walk_result_t result_q;
	logic         out_free;
	logic         advance;
	logic         in_take;

	smbw_step u_step (
		.state_cur (state_q),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.state_nxt (state_nxt),
		.emit      (emit),
		.result    (result)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && (out_free || !emit);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			state_q     <= walk_reset_state();
			out_valid_q <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance && emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
		if (advance && emit) begin
			result_q <= result;
		end
	end

	assign out_valid        = out_valid_q;
	assign struct_type      = result_q.struct_type;
	assign formatted_length = result_q.formatted_length;
	assign string_count     = result_q.string_count;
	assign struct_ordinal   = result_q.struct_ordinal;
	assign status           = result_q.status;
	assign table_done       = result_q.table_done;

	// The final byte of a buffer must leave a fresh walk with the counter cleared.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> state_q.phase == PH_HEADER
			&& state_q.structures_accepted == 16'd0)
		else $error("walk state not restarted after final byte");

	// Every stop of the walk ends the table.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> table_done)
		else $error("error result without table_done");

	// A result is never overwritten while it waits.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !(advance && emit))
		else $error("pending result overwritten");

	// The walker only drains after a stop that was reported.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && state_q.phase != PH_DRAIN && state_nxt.phase == PH_DRAIN |-> emit)
		else $error("drain entered without a result");

endmodule
